// ===== rtl/core/pvanq_pkg.sv =====
// Package: sizes, operation codes and field widths for the voice allocator.
package pvanq_pkg;
    localparam int VOICE_COUNT_DEF   = 18;
    localparam int QUEUE_DEPTH_DEF   = 8;
    localparam int CHANNEL_COUNT_DEF = 16;

    localparam int OP_W    = 3;
    localparam int CHAN_W  = 4;
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int VOICE_W = 5;
    localparam int MAP_W   = 5;

    localparam logic [MAP_W-1:0] NO_CHANNEL = 5'd31;
    localparam logic [VEL_W-1:0] PEDAL_THRESHOLD = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_NOTE_ON  = 3'd0,
        OP_NOTE_OFF = 3'd1,
        OP_PEDAL    = 3'd2,
        OP_ALL_OFF  = 3'd3,
        OP_TOGGLE   = 3'd4
    } t_op;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic [NOTE_W-1:0]  note;
        logic [VEL_W-1:0]   vel;
        logic               retrig;
        logic               last;
    } t_result;
endpackage

// ===== rtl/core/pvanq_out_reg.sv =====
// Output register: one result item held until the consumer takes it.
module pvanq_out_reg
    import pvanq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_data,
    output logic    o_full,
    input  logic    i_take,
    output t_result o_data
);
    logic    r_full;
    t_result r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_load) begin
            r_full <= 1'b1;
        end else if (i_take) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_full = r_full;
    assign o_data = r_data;

`ifndef SYNTHESIS
    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_full || i_take)) else $error("load over unread item");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && !i_take) |=> (r_full && $stable(r_data)))
        else $error("item changed while held");
    a_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && i_take && !i_load) |=> !r_full) else $error("item not dropped");
`endif
endmodule

// ===== rtl/core/poly_voice_allocator_note_queue.sv =====
// Top level: polyphonic voice allocator with note stealing and per-channel note queues.
// An item is accepted in the idle state and then processed by a sequencer that examines
// one voice per cycle, pausing for its writes, through a single compare unit. A note-on
// of zero velocity is handled as a note-off. Any other note-on makes a retrigger pass
// over all voices and, if no voice retriggers, scans the channel's queue, makes up to
// two free-voice passes and a steal pass from the rotation pointer, and after its write
// a rotation pass. A note-off makes one pass and may pop the queue; a toggle either pops
// the queue or makes one pass. A pedal release that refills many held voices takes
// longest, since each refill pops the queue. Each voice write waits while the previous
// result cannot yet be handed to the output register. Ready is low from acceptance until
// the item's last result has been handed to the output register; an item with an
// out-of-range channel is dropped and ready stays high. Reset clears all voice and channel
// state at once; the queue memory needs no clearing pass since fill counts guard every read.
module poly_voice_allocator_note_queue
    import pvanq_pkg::*;
#(
    parameter int VOICE_COUNT   = VOICE_COUNT_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [CHAN_W-1:0]  i_channel,
    input  logic [NOTE_W-1:0]  i_note,
    input  logic [VEL_W-1:0]   i_velocity,
    input  logic [VOICE_W-1:0] i_voice,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [VOICE_W-1:0] o_voice_index,
    output logic [NOTE_W-1:0]  o_voice_note,
    output logic [VEL_W-1:0]   o_voice_velocity,
    output logic               o_retrigger,
    output logic               o_last
);
    localparam int VI_W = $clog2(VOICE_COUNT);
    localparam int CI_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int QL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int KC_W = $clog2(VOICE_COUNT + 1);
    localparam int QM_D = CHANNEL_COUNT * QUEUE_DEPTH;
    localparam int QA_W = $clog2(QM_D);
    localparam logic [VI_W-1:0] VLAST = VI_W'(VOICE_COUNT - 1);
    localparam logic [QL_W-1:0] QFULL = QL_W'(QUEUE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_ON_RETRIG, S_ON_FREE1, S_ON_FREE2, S_ON_STEAL, S_ON_PUSH,
        S_ADV, S_OFF_FIND, S_OFF_ACT, S_RMQ, S_RMQ_CMP, S_DEL, S_DEL_WR, S_POP, S_POP_CAP,
        S_PEDAL_SCAN, S_ALL_SCAN, S_ALL_NEXT, S_TOG, S_TOG_COUNT, S_WRITE, S_EMIT
    } t_state;

    t_state r_state, r_ret, r_wret;

    logic [MAP_W-1:0]  r_map   [VOICE_COUNT];
    logic [NOTE_W-1:0] r_vnote [VOICE_COUNT];
    logic [VEL_W-1:0]  r_vvel  [VOICE_COUNT];
    logic              r_held  [VOICE_COUNT];
    logic [VI_W-1:0]   r_rot   [CHANNEL_COUNT];
    logic              r_pdown [CHANNEL_COUNT];
    logic [QL_W-1:0]   r_qlen  [CHANNEL_COUNT];
    logic [NOTE_W+VEL_W-1:0] r_qmem [QM_D];
    logic [NOTE_W+VEL_W-1:0] r_qrd;

    logic [OP_W-1:0]    r_op;
    logic [CI_W-1:0]    r_c;
    logic [NOTE_W-1:0]  r_note;
    logic [VEL_W-1:0]   r_vel;
    logic [VOICE_W-1:0] r_tv;
    logic [VI_W-1:0]    r_v;
    logic [KC_W-1:0]    r_k;
    logic [QL_W-1:0]    r_qi;
    logic [VI_W-1:0]    r_t;
    logic [NOTE_W-1:0]  r_wn;
    logic [VEL_W-1:0]   r_wv;
    logic               r_wclr;
    t_result            r_res;
    logic               r_pend_valid;
    logic               r_cnt_any;

    logic    ob_load, ob_full, ob_take;
    t_result ob_data, ob_q;

    logic [VI_W-1:0]         v_nx;
    logic                    on_ch;
    logic [QA_W-1:0]         qbase;
    logic [QA_W-1:0]         q_raddr;
    logic [QA_W-1:0]         q_waddr;
    logic                    q_we;
    logic                    q_full;
    logic [NOTE_W+VEL_W-1:0] q_wdata;
    logic [NOTE_W-1:0]       qrd_note;
    logic [VEL_W-1:0]        qrd_vel;

    assign v_nx     = (r_v == VLAST) ? '0 : r_v + VI_W'(1);
    assign on_ch    = (r_map[r_v] == MAP_W'(r_c));
    assign qbase    = QA_W'(r_c) * QA_W'(QUEUE_DEPTH);
    assign q_full   = (r_qlen[r_c] == QFULL);
    assign qrd_note = r_qrd[NOTE_W+VEL_W-1:VEL_W];
    assign qrd_vel  = r_qrd[VEL_W-1:0];

    assign ob_take = o_valid && i_ready;
    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        case (r_state)
            S_RMQ:   q_raddr = qbase + QA_W'(r_qi);
            S_DEL:   q_raddr = qbase + QA_W'(r_qi + QL_W'(1));
            default: q_raddr = qbase;
        endcase
    end

    assign q_we    = (r_state == S_DEL_WR) || (r_state == S_ON_PUSH);
    assign q_waddr = (r_state == S_ON_PUSH) ?
                     (qbase + (q_full ? QA_W'(QUEUE_DEPTH - 1) : QA_W'(r_qlen[r_c]))) :
                     (qbase + QA_W'(r_qi));
    assign q_wdata = (r_state == S_ON_PUSH) ? {r_vnote[r_t], r_vvel[r_t]} : r_qrd;

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_qmem[q_waddr] <= q_wdata;
        end
        r_qrd <= r_qmem[q_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= S_IDLE;
            r_wret <= S_IDLE;
            r_pend_valid <= 1'b0;
            r_c <= '0;
            for (int i = 0; i < VOICE_COUNT; i++) begin
                r_map[i] <= '0; r_vnote[i] <= '0; r_vvel[i] <= '0; r_held[i] <= 1'b0;
            end
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                r_rot[i] <= '0; r_pdown[i] <= 1'b0; r_qlen[i] <= '0;
            end
        end else begin
            case (r_state)
            S_IDLE: if (i_valid) begin
                r_op <= i_operation;
                r_c <= CI_W'(i_channel);
                r_note <= i_note; r_vel <= i_velocity; r_tv <= i_voice;
                r_state <= (32'(i_channel) < CHANNEL_COUNT) ? S_DISPATCH : S_IDLE;
            end
            S_DISPATCH: begin
                case (r_op)
                OP_NOTE_ON: begin
                    if (r_note == '0) r_state <= S_EMIT;
                    else if (r_vel == '0) begin
                        r_v <= r_rot[r_c]; r_k <= '0; r_state <= S_OFF_FIND;
                    end else begin
                        r_v <= '0; r_state <= S_ON_RETRIG;
                    end
                end
                OP_NOTE_OFF: begin
                    r_v <= r_rot[r_c]; r_k <= '0;
                    r_state <= (r_note == '0) ? S_EMIT : S_OFF_FIND;
                end
                OP_PEDAL: begin
                    r_pdown[r_c] <= (r_vel >= PEDAL_THRESHOLD);
                    r_v <= '0;
                    r_state <= (r_vel >= PEDAL_THRESHOLD) ? S_EMIT : S_PEDAL_SCAN;
                end
                OP_ALL_OFF: begin
                    r_v <= '0; r_state <= S_ALL_SCAN;
                end
                OP_TOGGLE: r_state <= (32'(r_tv) < VOICE_COUNT) ? S_TOG : S_EMIT;
                default: r_state <= S_EMIT;
                endcase
            end
            S_ON_RETRIG: begin
                if (on_ch && r_vvel[r_v] != '0 && r_vnote[r_v] == r_note) begin
                    r_t <= r_v; r_wn <= r_note; r_wv <= r_vel; r_wclr <= 1'b0;
                    r_wret <= S_EMIT; r_state <= S_WRITE;
                end else if (r_v == VLAST) begin
                    r_v <= r_rot[r_c]; r_k <= '0;
                    r_qi <= '0; r_ret <= S_ON_FREE1; r_state <= S_RMQ;
                end else r_v <= v_nx;
            end
            S_RMQ: begin
                if (r_qi >= r_qlen[r_c]) r_state <= r_ret;
                else r_state <= S_RMQ_CMP;
            end
            S_RMQ_CMP: begin
                if (qrd_note == r_note) r_state <= S_DEL;
                else begin
                    r_qi <= r_qi + QL_W'(1); r_state <= S_RMQ;
                end
            end
            S_DEL: begin
                if (r_qi + QL_W'(1) >= r_qlen[r_c]) begin
                    r_qlen[r_c] <= r_qlen[r_c] - QL_W'(1);
                    r_state <= r_ret;
                end else r_state <= S_DEL_WR;
            end
            S_DEL_WR: begin
                r_qi <= r_qi + QL_W'(1);
                r_state <= S_DEL;
            end
            S_ON_FREE1, S_ON_FREE2: begin
                if (on_ch && r_vvel[r_v] == '0 && !r_held[r_v] &&
                    (r_state == S_ON_FREE2 || r_vnote[r_v] == r_note)) begin
                    r_t <= r_v; r_wn <= r_note; r_wv <= r_vel; r_wclr <= 1'b0;
                    r_v <= v_nx; r_k <= '0;
                    r_wret <= S_ADV; r_state <= S_WRITE;
                end else if (r_k == KC_W'(VOICE_COUNT - 1)) begin
                    r_v <= r_rot[r_c]; r_k <= '0;
                    r_state <= (r_state == S_ON_FREE1) ? S_ON_FREE2 : S_ON_STEAL;
                end else begin
                    r_v <= v_nx; r_k <= r_k + KC_W'(1);
                end
            end
            S_ON_STEAL: begin
                if (on_ch) begin
                    r_rot[r_c] <= r_v; r_t <= r_v;
                    r_wn <= r_note; r_wv <= r_vel; r_wclr <= 1'b0;
                    r_v <= v_nx; r_k <= '0; r_wret <= S_ADV;
                    r_state <= r_held[r_v] ? S_WRITE : S_ON_PUSH;
                end else if (r_k == KC_W'(VOICE_COUNT - 1)) r_state <= S_EMIT;
                else begin
                    r_v <= v_nx; r_k <= r_k + KC_W'(1);
                end
            end
            S_ON_PUSH: begin
                if (!q_full) r_qlen[r_c] <= r_qlen[r_c] + QL_W'(1);
                r_state <= S_WRITE;
            end
            S_ADV: begin
                if (on_ch) begin
                    r_rot[r_c] <= r_v; r_state <= S_EMIT;
                end else if (r_k == KC_W'(VOICE_COUNT - 1)) r_state <= S_EMIT;
                else begin
                    r_v <= v_nx; r_k <= r_k + KC_W'(1);
                end
            end
            S_OFF_FIND: begin
                if (on_ch && r_vvel[r_v] != '0 && r_vnote[r_v] == r_note && !r_held[r_v])
                begin
                    r_t <= r_v; r_state <= S_OFF_ACT;
                end else if (r_k == KC_W'(VOICE_COUNT - 1)) begin
                    r_qi <= '0; r_ret <= S_EMIT; r_state <= S_RMQ;
                end else begin
                    r_v <= v_nx; r_k <= r_k + KC_W'(1);
                end
            end
            S_OFF_ACT: begin
                if (r_pdown[r_c]) begin
                    r_held[r_t] <= 1'b1; r_state <= S_EMIT;
                end else begin
                    r_wclr <= 1'b0; r_wret <= S_EMIT; r_state <= S_POP;
                end
            end
            S_POP: begin
                if (r_qlen[r_c] == '0) begin
                    r_wn <= '0; r_wv <= '0; r_state <= S_WRITE;
                end else r_state <= S_POP_CAP;
            end
            S_POP_CAP: begin
                r_wn <= qrd_note; r_wv <= qrd_vel;
                r_qi <= '0; r_ret <= S_WRITE; r_state <= S_DEL;
            end
            S_PEDAL_SCAN: begin
                if (on_ch && r_held[r_v]) begin
                    r_t <= r_v; r_wclr <= 1'b0;
                    r_wret <= S_PEDAL_SCAN; r_state <= S_POP;
                end else if (r_v == VLAST) r_state <= S_EMIT;
                else r_v <= v_nx;
            end
            S_ALL_SCAN: begin
                if (on_ch) begin
                    r_t <= r_v; r_wn <= '0; r_wv <= '0; r_wclr <= 1'b0;
                    r_wret <= S_ALL_NEXT; r_state <= S_WRITE;
                end else if (r_v == VLAST) begin
                    r_qlen[r_c] <= '0; r_state <= S_EMIT;
                end else r_v <= v_nx;
            end
            S_ALL_NEXT: begin
                if (r_v == VLAST) begin
                    r_qlen[r_c] <= '0; r_state <= S_EMIT;
                end else begin
                    r_v <= v_nx; r_state <= S_ALL_SCAN;
                end
            end
            S_TOG: begin
                r_t <= VI_W'(r_tv);
                if (r_map[VI_W'(r_tv)] != MAP_W'(r_c)) begin
                    r_map[VI_W'(r_tv)] <= MAP_W'(r_c);
                    r_wclr <= 1'b0; r_wret <= S_EMIT; r_state <= S_POP;
                end else begin
                    r_map[VI_W'(r_tv)] <= NO_CHANNEL;
                    r_cnt_any <= 1'b0; r_v <= '0; r_state <= S_TOG_COUNT;
                end
            end
            S_TOG_COUNT: begin
                if (r_v == VLAST) begin
                    if (!(on_ch || r_cnt_any)) r_qlen[r_c] <= '0;
                    r_wn <= '0; r_wv <= '0; r_wclr <= 1'b1;
                    r_wret <= S_EMIT; r_state <= S_WRITE;
                end else begin
                    if (on_ch) r_cnt_any <= 1'b1;
                    r_v <= v_nx;
                end
            end
            S_WRITE: begin
                if (!r_pend_valid || ob_load) begin
                    r_res.voice <= VOICE_W'(r_t);
                    r_res.retrig <= (!r_wclr && r_wn != '0 && r_wn == r_vnote[r_t]);
                    r_res.last <= 1'b0;
                    if (r_wclr) begin
                        r_vnote[r_t] <= '0; r_vvel[r_t] <= '0;
                        r_res.note <= '0; r_res.vel <= '0;
                    end else if (r_wn == '0) begin
                        r_vvel[r_t] <= '0;
                        r_res.note <= r_vnote[r_t]; r_res.vel <= '0;
                    end else begin
                        r_vnote[r_t] <= r_wn; r_vvel[r_t] <= r_wv;
                        r_res.note <= r_wn; r_res.vel <= r_wv;
                    end
                    r_held[r_t] <= 1'b0;
                    r_pend_valid <= 1'b1;
                    r_state <= r_wret;
                end
            end
            S_EMIT: begin
                if (!r_pend_valid) r_state <= S_IDLE;
                else if (ob_load) begin
                    r_pend_valid <= 1'b0; r_state <= S_IDLE;
                end
            end
            default: r_state <= S_IDLE;
            endcase
        end
    end

    // hand on the held item; in S_EMIT it is the final one and carries last
    always_comb begin
        ob_data = r_res;
        ob_data.last = (r_state == S_EMIT);
    end
    assign ob_load = r_pend_valid && (!ob_full || ob_take) &&
                     (r_state == S_EMIT || r_state == S_WRITE);

    pvanq_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (ob_load),
        .i_data  (ob_data),
        .o_full  (ob_full),
        .i_take  (ob_take),
        .o_data  (ob_q)
    );
    assign o_valid          = ob_full;
    assign o_voice_index    = ob_q.voice;
    assign o_voice_note     = ob_q.note;
    assign o_voice_velocity = ob_q.vel;
    assign o_retrigger      = ob_q.retrig;
    assign o_last           = ob_q.last;

`ifndef SYNTHESIS
    a_not_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_qlen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qlen[r_c] <= QFULL) else $error("queue overfilled");
    a_rot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_rot[r_c]) < VOICE_COUNT) else $error("pointer out of range");
`endif
endmodule
